### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is asserted
`define SFS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define SFS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg
// Types, codes and widths shared by the sprite frame sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sfs_pkg;

    localparam int FRAME_W   = 12;
    localparam int REQ_W     = FRAME_W + 1;
    localparam int FCNT_W    = 13;
    localparam int COLS_W    = 9;
    localparam int CELL_W    = 11;
    localparam int MODE_W    = 3;
    localparam int ACC_W     = 32;
    localparam int ELAPSED_W = 24;
    localparam int X_W       = 18;
    localparam int Y_W       = 22;
    localparam int KIND_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 56;
    localparam int CNT_W     = $clog2(FRAME_W);

    localparam logic [FCNT_W-1:0] FCNT_RESET     = FCNT_W'(1);
    localparam logic [COLS_W-1:0] COLS_RESET     = COLS_W'(1);
    localparam logic [CELL_W-1:0] CELL_RESET     = CELL_W'(1);
    localparam logic [ACC_W-1:0]  INTERVAL_RESET = ACC_W'(41667);

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAY_MODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL    = 3'd5;

    localparam logic [MODE_W-1:0] MODE_LOOP       = 3'd1;
    localparam logic [MODE_W-1:0] MODE_HOLD_LAST  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ROW_STOP   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ROW_LOOP   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ONCE_ZERO  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_ROW_RETURN = 3'd6;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK    = 3'd0,
        KIND_PLAY    = 3'd1,
        KIND_STOP    = 3'd2,
        KIND_SET     = 3'd3,
        KIND_RESTART = 3'd4
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ADD,
        ST_CMP,
        ST_DIV_OLD,
        ST_APPLY,
        ST_DIV_NEW,
        ST_MUL,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic div_load;
        logic set_run;
        logic clr_run;
        logic restart;
        logic req_set;
        logic add;
        logic cmp;
        logic div_step;
        logic apply;
        logic mul;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              run;
        logic              reached;
        logic              need_row_end;
        logic              out_busy;
    } t_status;

endpackage

`default_nettype wire

### rtl/sfs_ctrl.sv
// ----------------------------------------------------------------------------
// sfs_ctrl
// Sequencer state machine: decodes the word kind and steps the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_ctrl
    import sfs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_last_step;

    assign w_last_step = (r_cnt == CNT_W'(FRAME_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = i_rst_n;
                if (i_s_tvalid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                o_cmd.div_load = 1'b1;
                n_cnt          = '0;
                case (i_status.kind)
                    KIND_TICK:    n_state = i_status.run ? ST_ADD : ST_FINISH;
                    KIND_PLAY: begin
                        o_cmd.set_run = 1'b1;
                        n_state       = ST_FINISH;
                    end
                    KIND_STOP: begin
                        o_cmd.clr_run = 1'b1;
                        n_state       = ST_FINISH;
                    end
                    KIND_SET: begin
                        o_cmd.req_set = 1'b1;
                        n_state       = i_status.need_row_end ? ST_DIV_OLD : ST_APPLY;
                    end
                    KIND_RESTART: begin
                        o_cmd.restart = 1'b1;
                        n_state       = ST_FINISH;
                    end
                    default:      n_state = ST_FINISH;
                endcase
            end
            ST_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.cmp = 1'b1;
                if (!i_status.reached) begin
                    n_state = ST_FINISH;
                end else if (i_status.need_row_end) begin
                    n_state = ST_DIV_OLD;
                end else begin
                    n_state = ST_APPLY;
                end
            end
            ST_DIV_OLD: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (w_last_step) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                o_cmd.apply = 1'b1;
                n_cnt       = '0;
                n_state     = ST_DIV_NEW;
            end
            ST_DIV_NEW: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (w_last_step) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_FINISH;
            end
            ST_FINISH: begin
                if (!i_status.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

### rtl/sfs_datapath.sv
// ----------------------------------------------------------------------------
// sfs_datapath
// Config registers, accumulator, frame state, shared divider and output word.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_datapath
    import sfs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0]  i_cfg_data,
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    input  wire logic [KIND_W-1:0]     i_s_tuser,
    input  wire logic                  i_m_tready,
    output logic                       o_m_tvalid,
    output logic [OUT_DATA_W-1:0]      o_m_tdata,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status
);

    logic [FCNT_W-1:0]    r_frame_count;
    logic [COLS_W-1:0]    r_columns;
    logic [CELL_W-1:0]    r_cell_w;
    logic [CELL_W-1:0]    r_cell_h;
    logic [MODE_W-1:0]    r_mode;
    logic [ACC_W-1:0]     r_interval;

    logic [FRAME_W-1:0]   r_frame;
    logic [ACC_W-1:0]     r_acc;
    logic                 r_run;
    logic [X_W-1:0]       r_org_x;
    logic [Y_W-1:0]       r_org_y;
    logic                 r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;

    logic [KIND_W-1:0]    r_kind;
    logic [ELAPSED_W-1:0] r_elapsed;
    logic [FRAME_W-1:0]   r_request;
    logic [ACC_W-1:0]     r_sum;
    logic [REQ_W-1:0]     r_req;
    logic [COLS_W-1:0]    r_div_rem;
    logic [FRAME_W-1:0]   r_div_quo;

    logic [COLS_W-1:0]    w_cols;
    logic [COLS_W-1:0]    w_cols_m1;
    logic [ACC_W:0]       w_sum_full;
    logic [COLS_W:0]      w_trial;
    logic                 w_fit;
    logic [COLS_W:0]      w_trial_sub;
    logic                 w_at_row_end;
    logic                 w_req_ge;
    logic [REQ_W-1:0]     w_row_back;
    logic [REQ_W-1:0]     w_last;
    logic [REQ_W-1:0]     w_new_cur;
    logic                 w_new_run;
    logic [COLS_W+CELL_W-1:0]  w_prod_x;
    logic [FRAME_W+CELL_W-1:0] w_prod_y;

    assign w_cols     = (r_columns == '0) ? COLS_W'(1) : r_columns;
    assign w_cols_m1  = w_cols - 1'b1;
    assign w_sum_full = {1'b0, r_acc} + {{(ACC_W - ELAPSED_W + 1){1'b0}}, r_elapsed};

    assign w_trial     = {r_div_rem, r_div_quo[FRAME_W-1]};
    assign w_fit       = (w_trial >= {1'b0, w_cols});
    assign w_trial_sub = w_trial - {1'b0, w_cols};

    assign w_at_row_end = (r_div_rem == w_cols_m1);
    assign w_req_ge     = (r_req >= r_frame_count);
    assign w_row_back   = {1'b0, r_frame} - {{(REQ_W - COLS_W){1'b0}}, w_cols_m1};
    assign w_last       = (r_frame_count != '0) ? (r_frame_count - 1'b1) : '0;

    always_comb begin
        w_new_cur = r_req;
        w_new_run = r_run;
        case (r_mode)
            MODE_LOOP: begin
                if (w_req_ge) w_new_cur = '0;
            end
            MODE_HOLD_LAST: begin
                if (w_req_ge) begin
                    w_new_cur = w_last;
                    w_new_run = 1'b0;
                end
            end
            MODE_ROW_STOP: begin
                if (w_at_row_end) begin
                    w_new_cur = {1'b0, r_frame};
                    w_new_run = 1'b0;
                end
            end
            MODE_ROW_LOOP: begin
                if (w_at_row_end) w_new_cur = w_row_back;
            end
            MODE_ONCE_ZERO: begin
                if (w_req_ge) begin
                    w_new_cur = '0;
                    w_new_run = 1'b0;
                end
            end
            MODE_ROW_RETURN: begin
                if (w_at_row_end) begin
                    w_new_cur = w_row_back;
                    w_new_run = 1'b0;
                end
            end
            default: w_new_cur = r_req;
        endcase
    end

    assign w_prod_x = r_div_rem * r_cell_w;
    assign w_prod_y = r_div_quo * r_cell_h;

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= FCNT_RESET;
            r_columns     <= COLS_RESET;
            r_cell_w      <= CELL_RESET;
            r_cell_h      <= CELL_RESET;
            r_mode        <= '0;
            r_interval    <= INTERVAL_RESET;
            r_frame       <= '0;
            r_acc         <= '0;
            r_run         <= 1'b0;
            r_org_x       <= '0;
            r_org_y       <= '0;
            r_m_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_FRAME_COUNT: r_frame_count <= i_cfg_data[FCNT_W-1:0];
                    CFG_COLUMNS:     r_columns     <= i_cfg_data[COLS_W-1:0];
                    CFG_CELL_WIDTH:  r_cell_w      <= i_cfg_data[CELL_W-1:0];
                    CFG_CELL_HEIGHT: r_cell_h      <= i_cfg_data[CELL_W-1:0];
                    CFG_PLAY_MODE:   r_mode        <= i_cfg_data[MODE_W-1:0];
                    CFG_INTERVAL:    r_interval    <= i_cfg_data[ACC_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.set_run) r_run <= 1'b1;
            if (i_cmd.clr_run) r_run <= 1'b0;
            if (i_cmd.restart) begin
                r_frame <= '0;
                r_acc   <= '0;
                r_run   <= 1'b0;
            end
            if (i_cmd.cmp) begin
                r_acc <= (r_sum >= r_interval) ? '0 : r_sum;
            end
            if (i_cmd.apply) begin
                r_frame <= w_new_cur[FRAME_W-1:0];
                r_run   <= w_new_run;
            end
            if (i_cmd.mul) begin
                r_org_x <= w_prod_x[X_W-1:0];
                r_org_y <= w_prod_y[Y_W-1:0];
            end
            if (i_cmd.emit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // working registers and output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= i_s_tuser;
            r_elapsed <= i_s_tdata[ELAPSED_W-1:0];
            r_request <= i_s_tdata[ELAPSED_W +: FRAME_W];
        end
        if (i_cmd.add) begin
            r_sum <= w_sum_full[ACC_W] ? '1 : w_sum_full[ACC_W-1:0];
        end
        if (i_cmd.req_set) begin
            r_req <= {1'b0, r_request};
        end else if (i_cmd.cmp) begin
            r_req <= {1'b0, r_frame} + 1'b1;
        end
        if (i_cmd.div_load) begin
            r_div_rem <= '0;
            r_div_quo <= r_frame;
        end else if (i_cmd.apply) begin
            r_div_rem <= '0;
            r_div_quo <= w_new_cur[FRAME_W-1:0];
        end else if (i_cmd.div_step) begin
            r_div_rem <= w_fit ? w_trial_sub[COLS_W-1:0] : w_trial[COLS_W-1:0];
            r_div_quo <= {r_div_quo[FRAME_W-2:0], w_fit};
        end
        if (i_cmd.emit) begin
            r_m_data <= {{(OUT_DATA_W - FRAME_W - X_W - Y_W - 1){1'b0}},
                         r_run, r_org_y, r_org_x, r_frame};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    assign o_status.kind         = r_kind;
    assign o_status.run          = r_run;
    assign o_status.reached      = (r_sum >= r_interval);
    assign o_status.need_row_end = (r_mode == MODE_ROW_STOP) || (r_mode == MODE_ROW_LOOP)
                                   || (r_mode == MODE_ROW_RETURN);
    assign o_status.out_busy     = r_m_valid && !i_m_tready;

endmodule

`default_nettype wire

### rtl/sprite_frame_sequencer.sv
// Path per word: play, stop, restart, unknown kinds and ticks while stopped go to finish;
// a tick that does not advance adds the add and compare steps; set frame and an advancing
// tick also run apply, the new-frame divide and the multiply, plus an old-frame divide
// first in the row modes. Throughput: one word at a time; the next word is taken only
// after the result is loaded into the output register, which output stalls hold back.
// Reset (synchronous, active low): stopped at frame 0, config at defaults, ready low.
// ----------------------------------------------------------------------------
// sprite_frame_sequencer
// Sprite-sheet animation sequencer: ticks, play control and sheet origin.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_frame_sequencer
    import sfs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0]  i_cfg_data,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,   // elapsed_us[23:0], frame_request[35:24]
    input  wire logic [KIND_W-1:0]     i_s_tuser,   // kind[2:0]
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0]      o_m_tdata    // frame_index[11:0], sheet_x[29:12],
                                                    // sheet_y[51:30], playing[52]
);

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = i_rst_n;

    sfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    sfs_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

endmodule

`default_nettype wire

### rtl/sfs_checker.sv
// ----------------------------------------------------------------------------
// sfs_checker
// Port-level checks on the sequencer handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sfs_checker
    import sfs_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_s_tvalid,
    input wire logic                  i_s_tready,
    input wire logic                  i_m_tvalid,
    input wire logic                  i_m_tready,
    input wire logic [OUT_DATA_W-1:0] i_m_tdata
);

    `SFS_ASSERT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata), "result word dropped or changed while stalled")
    `SFS_ASSERT(a_one_in_flight, i_clk, i_rst_n, i_s_tvalid && i_s_tready |=> !i_s_tready, "input taken while a word is in flight")
    `SFS_ASSERT(a_result_from_busy, i_clk, i_rst_n, $rose(i_m_tvalid) |-> $past(!i_s_tready), "result appeared without a word in flight")
    `SFS_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !i_m_tvalid, "result valid after reset")

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);

`default_nettype wire

### tb/sv/tb_sprite_frame_sequencer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sprite_frame_sequencer
// Self-checking bench: directed control words, accumulator saturation, every
// play mode under random sheet setups, a long output hold-off and a final
// gap-free stream. A local tracker of frame, timer and sheet origin predicts
// each result word, which is compared field by field as it leaves the block.
// ----------------------------------------------------------------------------

module tb_sprite_frame_sequencer;
    import sfs_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_REPORTS     = 30;
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    // result fields, frame_index in the low bits
    typedef struct packed {
        logic             playing;
        logic [Y_W-1:0]   y;
        logic [X_W-1:0]   x;
        logic [FRAME_W-1:0] frame;
    } sheet_pos_t;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [ELAPSED_W-1:0] elapsed;
        logic [FRAME_W-1:0]   req;
    } anim_cmd_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DAT_W-1:0]  i_cfg_data;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;   // elapsed_us[23:0], frame_request[35:24]
    logic [KIND_W-1:0]     i_s_tuser;   // kind[2:0]
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;   // frame_index[11:0], sheet_x[29:12],
                                        // sheet_y[51:30], playing[52]

    sprite_frame_sequencer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // tracked configuration
    logic [FCNT_W-1:0] cfg_fcnt     = FCNT_RESET;
    logic [COLS_W-1:0] cfg_cols     = COLS_RESET;
    logic [CELL_W-1:0] cfg_cw       = CELL_RESET;
    logic [CELL_W-1:0] cfg_ch       = CELL_RESET;
    logic [MODE_W-1:0] cfg_mode     = '0;
    logic [ACC_W-1:0]  cfg_interval = INTERVAL_RESET;

    // tracked animation state
    logic [FRAME_W-1:0] cur_frame = '0;
    logic [ACC_W-1:0]   acc_us    = '0;
    logic               running   = 1'b0;
    logic [X_W-1:0]     org_x     = '0;
    logic [Y_W-1:0]     org_y     = '0;

    sheet_pos_t pending_pos[$];
    sheet_pos_t got_pos;
    sheet_pos_t want_pos;

    int  err_count     = 0;
    int  cycle_count   = 0;
    int  words_sent    = 0;
    int  results_seen  = 0;
    int  frame_steps   = 0;
    int  setups_loaded = 0;
    bit  src_idle_en   = 1'b1;
    bit  sink_idle_en  = 1'b1;
    bit  hold_req      = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still owed",
                     cycle_count, pending_pos.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < MAX_REPORTS)
            $display("result %0d: %s got 0x%0h want 0x%0h", results_seen, what, got, want);
        err_count++;
    endtask

    function automatic void move_to_frame(input logic [REQ_W-1:0] req);
        logic [COLS_W-1:0] cols;
        logic [REQ_W-1:0]  nxt;
        logic              row_end;
        cols    = (cfg_cols == '0) ? COLS_W'(1) : cfg_cols;
        row_end = (32'(cur_frame) % 32'(cols)) == (32'(cols) - 32'd1);
        nxt     = REQ_W'(cur_frame);
        case (cfg_mode)
            MODE_LOOP: nxt = (req >= cfg_fcnt) ? '0 : req;
            MODE_HOLD_LAST: begin
                if (req >= cfg_fcnt) begin
                    nxt     = (cfg_fcnt != '0) ? cfg_fcnt - 1'b1 : '0;
                    running = 1'b0;
                end else begin
                    nxt = req;
                end
            end
            MODE_ROW_STOP: begin
                if (row_end) running = 1'b0;
                else         nxt = req;
            end
            MODE_ROW_LOOP: begin
                if (row_end) nxt = nxt - REQ_W'(cols - 1'b1);
                else         nxt = req;
            end
            MODE_ONCE_ZERO: begin
                if (req >= cfg_fcnt) begin
                    nxt     = '0;
                    running = 1'b0;
                end else begin
                    nxt = req;
                end
            end
            MODE_ROW_RETURN: begin
                if (row_end) begin
                    nxt     = nxt - REQ_W'(cols - 1'b1);
                    running = 1'b0;
                end else begin
                    nxt = req;
                end
            end
            default: nxt = req;
        endcase
        cur_frame = nxt[FRAME_W-1:0];
        org_x = X_W'((32'(cur_frame) % 32'(cols)) * 32'(cfg_cw));
        org_y = Y_W'((32'(cur_frame) / 32'(cols)) * 32'(cfg_ch));
    endfunction

    function automatic void advance_sheet_pos(input anim_cmd_t c);
        logic [ACC_W:0] sum;
        sheet_pos_t     p;
        case (c.kind)
            KIND_TICK: begin
                if (running) begin
                    sum    = {1'b0, acc_us} + {9'b0, c.elapsed};
                    acc_us = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
                    if (acc_us >= cfg_interval) begin
                        acc_us = '0;
                        move_to_frame(REQ_W'(cur_frame) + 1'b1);
                        frame_steps++;
                    end
                end
            end
            KIND_PLAY: running = 1'b1;
            KIND_STOP: running = 1'b0;
            KIND_SET:  move_to_frame({1'b0, c.req});
            KIND_RESTART: begin
                cur_frame = '0;
                acc_us    = '0;
                running   = 1'b0;
            end
            default: ;
        endcase
        p.frame   = cur_frame;
        p.x       = org_x;
        p.y       = org_y;
        p.playing = running;
        pending_pos.push_back(p);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_pos = o_m_tdata[FRAME_W+X_W+Y_W:0];
            results_seen++;
            if (pending_pos.size() == 0) begin
                report_mismatch("unexpected word, frame", 32'(got_pos.frame), '0);
            end else begin
                want_pos = pending_pos.pop_front();
                if (got_pos.frame !== want_pos.frame)
                    report_mismatch("frame_index", 32'(got_pos.frame), 32'(want_pos.frame));
                if (got_pos.x !== want_pos.x)
                    report_mismatch("sheet_x", 32'(got_pos.x), 32'(want_pos.x));
                if (got_pos.y !== want_pos.y)
                    report_mismatch("sheet_y", 32'(got_pos.y), 32'(want_pos.y));
                if (got_pos.playing !== want_pos.playing)
                    report_mismatch("playing", 32'(got_pos.playing), 32'(want_pos.playing));
            end
        end
    end

    // output side: random stalls, one long hold-off on request
    initial begin : sink
        int n;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_tready <= 1'b0;
                for (n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end else if (sink_idle_en && $urandom_range(0, 6) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    function automatic anim_cmd_t mk(input logic [KIND_W-1:0] kind,
                                     input logic [ELAPSED_W-1:0] elapsed,
                                     input logic [FRAME_W-1:0] req);
        anim_cmd_t c;
        c.kind    = kind;
        c.elapsed = elapsed;
        c.req     = req;
        return c;
    endfunction

    function automatic anim_cmd_t rand_cmd();
        anim_cmd_t   c;
        int unsigned r;
        r         = $urandom_range(0, 99);
        c.elapsed = ELAPSED_W'($urandom);
        c.req     = FRAME_W'($urandom);
        if (r < 56) begin
            c.kind = KIND_TICK;
            if ($urandom_range(0, 9) != 0 && cfg_interval <= 32'h00FF_FFFF)
                c.elapsed = ELAPSED_W'($urandom_range(0, cfg_interval));
        end else if (r < 72) begin
            c.kind = KIND_SET;
            if ($urandom_range(0, 4) != 0)
                c.req = FRAME_W'($urandom_range(0, 32'(cfg_fcnt) + 3));
        end else if (r < 84) begin
            c.kind = KIND_PLAY;
        end else if (r < 89) begin
            c.kind = KIND_STOP;
        end else if (r < 93) begin
            c.kind = KIND_RESTART;
        end else begin
            c.kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
        end
        return c;
    endfunction

    task automatic send_word(input anim_cmd_t c);
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_DATA_W'({c.req, c.elapsed});
        i_s_tuser  <= c.kind;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        advance_sheet_pos(c);
        words_sent++;
    endtask

    // drop the input, drain all owed results and let the block go quiet
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (pending_pos.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_FRAME_COUNT: cfg_fcnt     = val[FCNT_W-1:0];
            CFG_COLUMNS:     cfg_cols     = val[COLS_W-1:0];
            CFG_CELL_WIDTH:  cfg_cw       = val[CELL_W-1:0];
            CFG_CELL_HEIGHT: cfg_ch       = val[CELL_W-1:0];
            CFG_PLAY_MODE:   cfg_mode     = val[MODE_W-1:0];
            CFG_INTERVAL:    cfg_interval = val;
            default: ;
        endcase
    endtask

    task automatic load_setup(input logic [31:0] fc, input logic [31:0] cols,
                              input logic [31:0] cw, input logic [31:0] ch,
                              input logic [MODE_W-1:0] mode, input logic [31:0] iv);
        settle();
        write_reg(CFG_FRAME_COUNT, fc);
        write_reg(CFG_COLUMNS, cols);
        write_reg(CFG_CELL_WIDTH, cw);
        write_reg(CFG_CELL_HEIGHT, ch);
        write_reg(CFG_PLAY_MODE, 32'(mode));
        write_reg(CFG_INTERVAL, iv);
        i_cfg_valid <= 1'b0;
        setups_loaded++;
    endtask

    task automatic random_setup(input logic [MODE_W-1:0] mode, input int variant);
        logic [31:0] fc;
        logic [31:0] cols;
        logic [31:0] cw;
        logic [31:0] ch;
        logic [31:0] iv;
        logic [31:0] fc_pick[3]   = '{0, 4096, 8191};
        logic [31:0] cols_pick[3] = '{0, 256, 511};
        logic [31:0] cell_pick[3] = '{0, 1024, 2047};
        logic [31:0] iv_pick[3]   = '{0, 1, 41667};
        case (variant)
            0: begin
                fc   = $urandom_range(1, 24);
                cols = $urandom_range(1, 6);
                cw   = $urandom_range(1, 64);
                ch   = $urandom_range(1, 64);
                iv   = $urandom_range(0, 40);
            end
            1: begin
                fc   = fc_pick[$urandom_range(0, 2)];
                cols = cols_pick[$urandom_range(0, 2)];
                cw   = cell_pick[$urandom_range(0, 2)];
                ch   = cell_pick[$urandom_range(0, 2)];
                iv   = iv_pick[$urandom_range(0, 2)];
            end
            default: begin
                fc   = $urandom_range(0, 8191);
                cols = $urandom_range(0, 511);
                cw   = $urandom_range(0, 2047);
                ch   = $urandom_range(0, 2047);
                iv   = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 2000);
            end
        endcase
        load_setup(fc, cols, cw, ch, mode, iv);
    endtask

    task automatic test_directed();
        // reset setup: one frame, one column, free count
        send_word(mk(KIND_SPARE_LO, '1, '1));
        send_word(mk(KIND_SPARE_HI, '0, '0));
        send_word(mk(KIND_TICK, '1, '0));
        send_word(mk(KIND_SET, '0, '1));
        send_word(mk(KIND_SET, '1, '0));
        send_word(mk(KIND_PLAY, '0, '0));
        send_word(mk(KIND_TICK, '0, '0));
        send_word(mk(KIND_TICK, 24'd41666, '0));
        send_word(mk(KIND_TICK, 24'd1, '0));
        send_word(mk(KIND_TICK, '1, '1));
        send_word(mk(KIND_STOP, '1, '1));
        send_word(mk(KIND_TICK, '1, '0));
        send_word(mk(KIND_W'(KIND_SPARE_LO + 1'b1), '0, '1));
        send_word(mk(KIND_RESTART, '0, '0));
        // zero columns, zero interval, frame wrap at the top
        load_setup(1, 0, 2047, 2047, 3'd7, 0);
        send_word(mk(KIND_SET, '0, '1));
        send_word(mk(KIND_PLAY, '0, '0));
        send_word(mk(KIND_TICK, '0, '0));
        send_word(mk(KIND_TICK, '0, '0));
        // hold-last with no frames
        load_setup(0, 3, 5, 7, MODE_HOLD_LAST, 0);
        send_word(mk(KIND_PLAY, '0, '0));
        send_word(mk(KIND_TICK, '0, '0));
        send_word(mk(KIND_SET, '0, '1));
        send_word(mk(KIND_PLAY, '0, '0));
        send_word(mk(KIND_SET, '0, 12'd0));
    endtask

    task automatic test_saturation();
        int i;
        load_setup(8191, 511, 2047, 1, MODE_LOOP, 32'hFFFF_FFFF);
        send_word(mk(KIND_PLAY, '0, '0));
        for (i = 0; i < 260; i++) send_word(mk(KIND_TICK, '1, FRAME_W'($urandom)));
        send_word(mk(KIND_STOP, '0, '0));
    endtask

    task automatic test_play_modes();
        int m;
        int v;
        int i;
        for (m = 0; m < 8; m++) begin
            for (v = 0; v < 3; v++) begin
                src_idle_en  = ($urandom_range(0, 3) != 0);
                sink_idle_en = ($urandom_range(0, 3) != 0);
                random_setup(MODE_W'(m), v);
                send_word(mk(KIND_PLAY, ELAPSED_W'($urandom), FRAME_W'($urandom)));
                for (i = 0; i < 44; i++) send_word(rand_cmd());
            end
        end
    endtask

    task automatic test_backpressure();
        int i;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b1;
        random_setup(MODE_ROW_LOOP, 0);
        hold_req = 1'b1;
        send_word(mk(KIND_PLAY, '0, '0));
        for (i = 0; i < 119; i++) send_word(rand_cmd());
    endtask

    task automatic test_streaming();
        int i;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        random_setup(MODE_W'($urandom_range(0, 7)), 0);
        send_word(mk(KIND_PLAY, '0, '0));
        for (i = 0; i < 149; i++) send_word(rand_cmd());
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_saturation();
        test_play_modes();
        test_backpressure();
        test_streaming();
        settle();

        $display("covered %0d words over %0d register setups, all eight play modes",
                 words_sent, setups_loaded);
        $display("checked %0d result words, %0d timed frame steps, %0d mismatches",
                 results_seen, frame_steps, err_count);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
